// File: rtl/core/rms_pkg.sv
// shared types, codes and microcode program of the reverse motion supervisor
package rms_pkg;

    // fixed field widths
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int DIST_W      = 23;
    localparam int SPEED_W     = 16;
    localparam int TIMEOUT_W   = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int PC_W        = 4;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POSE   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd3;

    // run status codes
    localparam logic [STATUS_W-1:0] STATUS_IDLE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RUNNING   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SUCCEEDED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FAILED    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BACKUP_DISTANCE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKUP_SPEED    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_TIMEOUT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_PROGRESS    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STALL_TIMEOUT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SAFETY_ENABLE   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ALLOW_UNSAFE    = 3'd6;

    // configuration reset values
    localparam logic [DIST_W-1:0]           RST_BACKUP_DISTANCE = 23'd300;
    localparam logic signed [SPEED_W-1:0]   RST_BACKUP_SPEED    = -16'sd200;
    localparam logic [TIMEOUT_W-1:0]        RST_TOTAL_TIMEOUT   = 24'd2000;
    localparam logic [DIST_W-1:0]           RST_MIN_PROGRESS    = 23'd20;
    localparam logic [TIMEOUT_W-1:0]        RST_STALL_TIMEOUT   = 24'd1000;

    // datapath and control operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_DIFF,
        OP_SQ_X,
        OP_SQ_Y,
        OP_SUM,
        OP_ROOT,
        OP_MARK,
        OP_GO,
        OP_REPORT,
        OP_FAIL,
        OP_SUCCEED,
        OP_EMIT
    } op_t;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_RUNNING,
        C_TOTAL_TO,
        C_ROOT_MORE,
        C_STALL_TO,
        C_DIST_OK,
        C_UNSAFE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ucode_t;

    // program steps
    localparam logic [PC_W-1:0] STEP_IDLE    = 4'd0;
    localparam logic [PC_W-1:0] STEP_ENTRY   = 4'd1;
    localparam logic [PC_W-1:0] STEP_TOTAL   = 4'd2;
    localparam logic [PC_W-1:0] STEP_SQ_X    = 4'd3;
    localparam logic [PC_W-1:0] STEP_SQ_Y    = 4'd4;
    localparam logic [PC_W-1:0] STEP_SUM     = 4'd5;
    localparam logic [PC_W-1:0] STEP_ROOT    = 4'd6;
    localparam logic [PC_W-1:0] STEP_MARK    = 4'd7;
    localparam logic [PC_W-1:0] STEP_STALL   = 4'd8;
    localparam logic [PC_W-1:0] STEP_DIST    = 4'd9;
    localparam logic [PC_W-1:0] STEP_SAFE    = 4'd10;
    localparam logic [PC_W-1:0] STEP_GO      = 4'd11;
    localparam logic [PC_W-1:0] STEP_REPORT  = 4'd12;
    localparam logic [PC_W-1:0] STEP_FAIL    = 4'd13;
    localparam logic [PC_W-1:0] STEP_SUCCEED = 4'd14;
    localparam logic [PC_W-1:0] STEP_EMIT    = 4'd15;

    // control store: a taken condition jumps to target, otherwise pc advances
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            STEP_IDLE:    w = '{OP_NOP,     C_ALWAYS,      STEP_IDLE};
            STEP_ENTRY:   w = '{OP_DIFF,    C_NOT_RUNNING, STEP_REPORT};
            STEP_TOTAL:   w = '{OP_NOP,     C_TOTAL_TO,    STEP_FAIL};
            STEP_SQ_X:    w = '{OP_SQ_X,    C_NEVER,       STEP_IDLE};
            STEP_SQ_Y:    w = '{OP_SQ_Y,    C_NEVER,       STEP_IDLE};
            STEP_SUM:     w = '{OP_SUM,     C_NEVER,       STEP_IDLE};
            STEP_ROOT:    w = '{OP_ROOT,    C_ROOT_MORE,   STEP_ROOT};
            STEP_MARK:    w = '{OP_MARK,    C_NEVER,       STEP_IDLE};
            STEP_STALL:   w = '{OP_NOP,     C_STALL_TO,    STEP_FAIL};
            STEP_DIST:    w = '{OP_NOP,     C_DIST_OK,     STEP_SUCCEED};
            STEP_SAFE:    w = '{OP_NOP,     C_UNSAFE,      STEP_FAIL};
            STEP_GO:      w = '{OP_GO,      C_ALWAYS,      STEP_EMIT};
            STEP_REPORT:  w = '{OP_REPORT,  C_ALWAYS,      STEP_EMIT};
            STEP_FAIL:    w = '{OP_FAIL,    C_ALWAYS,      STEP_EMIT};
            STEP_SUCCEED: w = '{OP_SUCCEED, C_NEVER,       STEP_IDLE};
            STEP_EMIT:    w = '{OP_EMIT,    C_OUT_BUSY,    STEP_EMIT};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/rms_datapath.sv
// travel datapath: absolute differences, squares, sum and a bit-pair square root
module rms_datapath
    import rms_pkg::*;
#(
    parameter int POS_WIDTH = 24
)
(
    input  logic                        clk,
    input  op_t                         op,
    input  logic signed [POS_WIDTH-1:0] pos_x,
    input  logic signed [POS_WIDTH-1:0] pos_y,
    input  logic signed [POS_WIDTH-1:0] org_x,
    input  logic signed [POS_WIDTH-1:0] org_y,
    output logic                        root_more,
    output logic [POS_WIDTH:0]          travel
);

    localparam int RW  = POS_WIDTH + 1;
    localparam int SW  = 2 * POS_WIDTH + 2;
    localparam int RMW = RW + 2;
    localparam int IW  = $clog2(RW);

    logic [POS_WIDTH-1:0]   dx_reg, dx_next;
    logic [POS_WIDTH-1:0]   dy_reg, dy_next;
    logic [2*POS_WIDTH-1:0] prod_reg, prod_next;
    logic [SW-1:0]          rad_reg, rad_next;
    logic [RMW-1:0]         rem_reg, rem_next;
    logic [RW-1:0]          root_reg, root_next;
    logic [IW-1:0]          iter_reg, iter_next;

    logic [POS_WIDTH:0]     diff_x, diff_y;
    logic [POS_WIDTH:0]     abs_x, abs_y;
    logic [RMW-1:0]         rem_shift, trial;
    logic                   take;

    always_comb
    begin
        diff_x = {pos_x[POS_WIDTH-1], pos_x} - {org_x[POS_WIDTH-1], org_x};
        diff_y = {pos_y[POS_WIDTH-1], pos_y} - {org_y[POS_WIDTH-1], org_y};
        abs_x  = diff_x[POS_WIDTH] ? -diff_x : diff_x;
        abs_y  = diff_y[POS_WIDTH] ? -diff_y : diff_y;

        // one result bit per step
        rem_shift = {rem_reg[RMW-3:0], rad_reg[SW-1:SW-2]};
        trial     = {root_reg, 2'b01};
        take      = rem_shift >= trial;

        dx_next   = dx_reg;
        dy_next   = dy_reg;
        prod_next = prod_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        iter_next = iter_reg;

        unique case (op)
            OP_DIFF:
            begin
                dx_next = abs_x[POS_WIDTH-1:0];
                dy_next = abs_y[POS_WIDTH-1:0];
            end
            OP_SQ_X:
            begin
                prod_next = dx_reg * dx_reg;
            end
            OP_SQ_Y:
            begin
                rad_next  = SW'(prod_reg);
                prod_next = dy_reg * dy_reg;
            end
            OP_SUM:
            begin
                rad_next  = rad_reg + SW'(prod_reg);
                rem_next  = '0;
                root_next = '0;
                iter_next = IW'(RW - 1);
            end
            OP_ROOT:
            begin
                rem_next  = take ? (rem_shift - trial) : rem_shift;
                root_next = {root_reg[RW-2:0], take};
                rad_next  = {rad_reg[SW-3:0], 2'b00};
                iter_next = iter_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        prod_reg <= prod_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        iter_reg <= iter_next;
    end

    assign root_more = iter_reg != '0;
    assign travel    = root_reg;

endmodule

// File: rtl/core/reverse_motion_supervisor_core.sv
// top level of the reverse motion supervisor: sequencer, run state, config and result register
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------------
//   in      | request   | in_valid / in_stall   | kind, pos_x, pos_y, safe_ok
//   out     | result    | out_valid / out_stall | status, drive_speed, drive_valid
//   cfg     | write     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// tick and start requests finish in the cycle they are taken; a cancel goes to the emit step.
// a pose update runs the microcode program; its square root yields one bit per cycle.
// early exits (not running, total timeout) skip the travel computation.
// reset clears run state, counters and the output valid flag and loads config defaults.
// in_stall is high while the program runs; the result waits in the output register
// and the program holds in its last step while out_stall keeps that register full.
module reverse_motion_supervisor_core
    import rms_pkg::*;
#(
    parameter int POS_WIDTH  = 24,
    parameter int TICK_WIDTH = 24
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    // request channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [KIND_W-1:0]            kind,
    input  logic signed [POS_WIDTH-1:0]  pos_x,
    input  logic signed [POS_WIDTH-1:0]  pos_y,
    input  logic                         safe_ok,

    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [STATUS_W-1:0]          status,
    output logic signed [SPEED_W-1:0]    drive_speed,
    output logic                         drive_valid,

    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int RW  = POS_WIDTH + 1;                          // travel width
    localparam int DW  = (RW > DIST_W) ? RW : DIST_W;            // distance compare width
    localparam int MW  = DW + 1;                                 // mark plus step width
    localparam int TCW = (TICK_WIDTH > TIMEOUT_W) ? TICK_WIDTH : TIMEOUT_W;

    // configuration
    logic [DIST_W-1:0]          backup_distance_reg;
    logic signed [SPEED_W-1:0]  backup_speed_reg;
    logic [TIMEOUT_W-1:0]       total_timeout_reg;
    logic [DIST_W-1:0]          min_progress_reg;
    logic [TIMEOUT_W-1:0]       stall_timeout_reg;
    logic                       safety_enable_reg;
    logic                       allow_unsafe_reg;

    // run state
    logic [PC_W-1:0]            pc_reg, pc_next;
    logic [STATUS_W-1:0]        run_status_reg, run_status_next;
    logic signed [POS_WIDTH-1:0] origin_x_reg, origin_x_next;
    logic signed [POS_WIDTH-1:0] origin_y_reg, origin_y_next;
    logic [RW-1:0]              mark_reg, mark_next;
    logic [TICK_WIDTH-1:0]      elapsed_reg, elapsed_next;
    logic [TICK_WIDTH-1:0]      stall_ticks_reg, stall_ticks_next;

    // latched request payload
    logic signed [POS_WIDTH-1:0] pos_x_reg, pos_x_next;
    logic signed [POS_WIDTH-1:0] pos_y_reg, pos_y_next;
    logic                       safe_reg, safe_next;

    // pending result
    logic [STATUS_W-1:0]        res_status_reg, res_status_next;
    logic signed [SPEED_W-1:0]  res_speed_reg, res_speed_next;
    logic                       res_dvalid_reg, res_dvalid_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]        out_status_reg, out_status_next;
    logic signed [SPEED_W-1:0]  out_speed_reg, out_speed_next;
    logic                       out_dvalid_reg, out_dvalid_next;

    ucode_t                     uw;
    logic                       in_accept;
    logic                       out_busy;
    logic                       cond_hit;
    logic                       running;
    logic                       total_to, stall_to, dist_ok, mark_ok, unsafe;
    logic                       root_more;
    logic [RW-1:0]              travel;
    op_t                        dp_op;

    rms_datapath #(
        .POS_WIDTH (POS_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .op        (dp_op),
        .pos_x     (pos_x_reg),
        .pos_y     (pos_y_reg),
        .org_x     (origin_x_reg),
        .org_y     (origin_y_reg),
        .root_more (root_more),
        .travel    (travel)
    );

    assign uw        = ucode_rom(pc_reg);
    assign dp_op     = uw.op;
    assign in_stall  = pc_reg != STEP_IDLE;
    assign in_accept = in_valid && !in_stall;
    assign out_busy  = out_valid_reg && out_stall;
    assign cfg_ready = 1'b1;
    assign running   = run_status_reg == STATUS_RUNNING;

    // checks, judged by the program in the order total, mark, stall, distance, safety
    assign total_to = (total_timeout_reg != '0)
                   && (TCW'(elapsed_reg) > TCW'(total_timeout_reg));
    assign stall_to = (stall_timeout_reg != '0)
                   && (TCW'(stall_ticks_reg) > TCW'(stall_timeout_reg));
    assign mark_ok  = (min_progress_reg != '0)
                   && (MW'(travel) >= (MW'(mark_reg) + MW'(min_progress_reg)));
    assign dist_ok  = DW'(travel) >= DW'(backup_distance_reg);
    assign unsafe   = safety_enable_reg && !allow_unsafe_reg && !safe_reg;

    always_comb
    begin
        unique case (uw.cond)
            C_NEVER:       cond_hit = 1'b0;
            C_ALWAYS:      cond_hit = 1'b1;
            C_NOT_RUNNING: cond_hit = !running;
            C_TOTAL_TO:    cond_hit = total_to;
            C_ROOT_MORE:   cond_hit = root_more;
            C_STALL_TO:    cond_hit = stall_to;
            C_DIST_OK:     cond_hit = dist_ok;
            C_UNSAFE:      cond_hit = unsafe;
            C_OUT_BUSY:    cond_hit = out_busy;
            default:       cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next          = cond_hit ? uw.target : pc_reg + 1'b1;
        run_status_next  = run_status_reg;
        origin_x_next    = origin_x_reg;
        origin_y_next    = origin_y_reg;
        mark_next        = mark_reg;
        elapsed_next     = elapsed_reg;
        stall_ticks_next = stall_ticks_reg;
        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        safe_next        = safe_reg;
        res_status_next  = res_status_reg;
        res_speed_next   = res_speed_reg;
        res_dvalid_next  = res_dvalid_reg;
        out_status_next  = out_status_reg;
        out_speed_next   = out_speed_reg;
        out_dvalid_next  = out_dvalid_reg;
        out_valid_next   = out_valid_reg && out_stall;

        // request dispatch, only taken while the program sits in its idle step
        if (in_accept)
        begin
            unique case (kind)
                KIND_TICK:
                begin
                    if (running)
                    begin
                        if (elapsed_reg != '1)
                            elapsed_next = elapsed_reg + 1'b1;
                        if (stall_ticks_reg != '1)
                            stall_ticks_next = stall_ticks_reg + 1'b1;
                    end
                end
                KIND_START:
                begin
                    origin_x_next    = pos_x;
                    origin_y_next    = pos_y;
                    mark_next        = '0;
                    elapsed_next     = '0;
                    stall_ticks_next = '0;
                    run_status_next  = STATUS_RUNNING;
                end
                KIND_POSE:
                begin
                    pos_x_next = pos_x;
                    pos_y_next = pos_y;
                    safe_next  = safe_ok;
                    pc_next    = STEP_ENTRY;
                end
                KIND_CANCEL:
                begin
                    run_status_next = STATUS_IDLE;
                    res_status_next = STATUS_IDLE;
                    res_speed_next  = '0;
                    res_dvalid_next = 1'b1;
                    pc_next         = STEP_EMIT;
                end
            endcase
        end

        unique case (uw.op)
            OP_MARK:
            begin
                // progress renews the mark and restarts the stall count
                if (mark_ok)
                begin
                    mark_next        = travel;
                    stall_ticks_next = '0;
                end
            end
            OP_GO:
            begin
                res_status_next = run_status_reg;
                res_speed_next  = backup_speed_reg;
                res_dvalid_next = 1'b1;
            end
            OP_REPORT:
            begin
                res_status_next = run_status_reg;
                res_speed_next  = '0;
                res_dvalid_next = 1'b0;
            end
            OP_FAIL:
            begin
                run_status_next = STATUS_FAILED;
                res_status_next = STATUS_FAILED;
                res_speed_next  = '0;
                res_dvalid_next = 1'b1;
            end
            OP_SUCCEED:
            begin
                run_status_next = STATUS_SUCCEEDED;
                res_status_next = STATUS_SUCCEEDED;
                res_speed_next  = '0;
                res_dvalid_next = 1'b1;
            end
            OP_EMIT:
            begin
                // load once the output register is free or being taken
                if (!out_busy)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_speed_next  = res_speed_reg;
                    out_dvalid_next = res_dvalid_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // configuration writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backup_distance_reg <= RST_BACKUP_DISTANCE;
            backup_speed_reg    <= RST_BACKUP_SPEED;
            total_timeout_reg   <= RST_TOTAL_TIMEOUT;
            min_progress_reg    <= RST_MIN_PROGRESS;
            stall_timeout_reg   <= RST_STALL_TIMEOUT;
            safety_enable_reg   <= 1'b1;
            allow_unsafe_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BACKUP_DISTANCE: backup_distance_reg <= cfg_data[DIST_W-1:0];
                REG_BACKUP_SPEED:    backup_speed_reg    <= cfg_data[SPEED_W-1:0];
                REG_TOTAL_TIMEOUT:   total_timeout_reg   <= cfg_data[TIMEOUT_W-1:0];
                REG_MIN_PROGRESS:    min_progress_reg    <= cfg_data[DIST_W-1:0];
                REG_STALL_TIMEOUT:   stall_timeout_reg   <= cfg_data[TIMEOUT_W-1:0];
                REG_SAFETY_ENABLE:   safety_enable_reg   <= cfg_data[0];
                REG_ALLOW_UNSAFE:    allow_unsafe_reg    <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // control and run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg          <= STEP_IDLE;
            run_status_reg  <= STATUS_IDLE;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            mark_reg        <= '0;
            elapsed_reg     <= '0;
            stall_ticks_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            pc_reg          <= pc_next;
            run_status_reg  <= run_status_next;
            origin_x_reg    <= origin_x_next;
            origin_y_reg    <= origin_y_next;
            mark_reg        <= mark_next;
            elapsed_reg     <= elapsed_next;
            stall_ticks_reg <= stall_ticks_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_x_reg      <= pos_x_next;
        pos_y_reg      <= pos_y_next;
        safe_reg       <= safe_next;
        res_status_reg <= res_status_next;
        res_speed_reg  <= res_speed_next;
        res_dvalid_reg <= res_dvalid_next;
        out_status_reg <= out_status_next;
        out_speed_reg  <= out_speed_next;
        out_dvalid_reg <= out_dvalid_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign drive_speed = out_speed_reg;
    assign drive_valid = out_dvalid_reg;

    // a new result only appears from the emit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pc_reg == STEP_EMIT))
        else $error("result register loaded outside the emit step");

    // the stall count is cleared at least as often as the run count
    a_stall_le_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        stall_ticks_reg <= elapsed_reg)
        else $error("stall count exceeds elapsed count");

    // cancel always leaves the run idle
    a_cancel_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (kind == KIND_CANCEL) |=> run_status_reg == STATUS_IDLE)
        else $error("cancel did not return to idle");

    // the program leaves its idle step only on an accepted request
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == STEP_IDLE) && !in_accept |=> pc_reg == STEP_IDLE)
        else $error("program started without a request");

    // a stop or a pure report never carries a speed
    a_stop_no_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != STATUS_RUNNING) |-> out_speed_reg == '0)
        else $error("nonzero speed with a stop result");

endmodule
